@@ rtl/cps_pkg.sv @@
// Shared types and constants of the column percentile select unit.
`default_nettype none
package cps_pkg;

  localparam int VAL_W  = 32;
  localparam int COL_W  = 16;
  localparam int CNT_W  = 7;
  localparam int PCT_W  = 14;
  localparam int DATA_W = 48;
  localparam int ADDR_W = 1;
  localparam int WDATA_W = 14;

  localparam logic [ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [ADDR_W-1:0] REG_PERCENTILE   = 1'b1;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 7'd64;
  localparam logic [PCT_W-1:0] PERCENTILE_RESET   = 14'd5000;

  // Division by 10000 is a multiply by ceil(2^39 / 10000) and a shift of 39.
  localparam int RECIP_W  = 26;
  localparam int RECIP_SH = 39;
  localparam logic [RECIP_W-1:0] RECIP_10000 = 26'd54975582;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } chain_op_t;

  typedef struct packed {
    chain_op_t               op;
    logic signed [VAL_W-1:0] din;
  } chain_ctl_t;

endpackage
`default_nettype wire

@@ rtl/cps_cell.sv @@
// One cell of the sorted insertion chain.
`default_nettype none
module cps_cell (
  input  wire                              clk,
  input  wire  cps_pkg::chain_ctl_t        ctl,
  input  wire                              occ,
  input  wire                              left_keep,
  input  wire  signed [cps_pkg::VAL_W-1:0] left_val,
  input  wire  signed [cps_pkg::VAL_W-1:0] right_val,
  output logic signed [cps_pkg::VAL_W-1:0] val,
  output logic                             keep
);
  import cps_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  assign val  = val_r;
  assign keep = occ && !($signed(val_r) > $signed(ctl.din));

  always_comb begin
    case (ctl.op)
      OP_INSERT: begin
        if (keep) begin
          val_nxt = val_r;
        end else if (left_keep) begin
          val_nxt = ctl.din;
        end else begin
          val_nxt = left_val;
        end
      end
      OP_SHIFT: val_nxt = right_val;
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/column_percentile_select_unit.sv @@
// Top level of the column percentile select unit.
`default_nettype none
// Collects one column of samples in a chain of MAX_SAMPLES compare-and-shift cells that keeps
// them in ascending order, taking one sample per cycle. When the column's last sample arrives,
// the rank floor(count * percentile / 10000), clamped to count - 1, is computed over three
// registered steps, and the chain then shifts toward its first cell until the selected
// value reaches it. No sample is taken from the last sample's transfer until the result
// is loaded into the output register, which may still hold an earlier result while the
// next column fills.
module column_percentile_select_unit #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire  [cps_pkg::DATA_W-1:0]    in_tdata,   // sample_value, column_index
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [cps_pkg::DATA_W-1:0]    out_tdata,  // selected_value, column_out
  input  wire                           cfg_we,
  input  wire  [cps_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire  [cps_pkg::WDATA_W-1:0]   cfg_wdata
);
  import cps_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;
  localparam int PW = CW + PCT_W;
  localparam int MW = PW + RECIP_W;
  localparam int QW = CW + 1;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_SHIFT,
    ST_OUT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   sample_count_r;
  logic [PCT_W-1:0]   pct_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      cnt_r;
  logic [PW-1:0]      prod_r;
  logic [QW-1:0]      quot_r;
  logic [IW-1:0]      rank_r;
  logic [COL_W-1:0]   col_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;

  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      sc_ext;
  logic [CW-1:0]      count_inc;
  logic               accept;
  logic [MW-1:0]      recip_prod;
  chain_ctl_t         ctl;

  logic signed [VAL_W-1:0] cell_val  [MAX_SAMPLES];
  logic                    cell_keep [MAX_SAMPLES];

  assign in_tready  = rst_n && (state_r == ST_FILL);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sc_ext    = NW'(sample_count_r);
  assign count_inc = count_r + CW'(1);
  assign recip_prod = MW'(prod_r) * MW'(RECIP_10000);

  always_comb begin
    if (sc_ext == '0) begin
      n_eff = NW'(1);
    end else if (sc_ext > NW'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = sc_ext;
    end
  end

  always_comb begin
    ctl.din = $signed(in_tdata[VAL_W-1:0]);
    if (accept) begin
      ctl.op = OP_INSERT;
    end else if (state_r == ST_SHIFT && rank_r != '0) begin
      ctl.op = OP_SHIFT;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic                    lk;
    logic signed [VAL_W-1:0] lv;
    logic signed [VAL_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lv = cell_val[0];
    end else begin : g_mid
      assign lk = cell_keep[i-1];
      assign lv = cell_val[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    cps_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (IDX < count_r),
      .left_keep (lk),
      .left_val  (lv),
      .right_val (rv),
      .val       (cell_val[i]),
      .keep      (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_FILL;
      sample_count_r <= SAMPLE_COUNT_RESET;
      pct_r          <= PERCENTILE_RESET;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[CNT_W-1:0];
          REG_PERCENTILE:   pct_r          <= cfg_wdata[PCT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_FILL: begin
          if (accept) begin
            count_r <= count_inc;
            cnt_r   <= count_inc;
            col_r   <= in_tdata[VAL_W +: COL_W];
            if (NW'(count_inc) >= n_eff) begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= PW'(cnt_r) * PW'(pct_r);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quot_r  <= recip_prod[RECIP_SH +: QW];
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (quot_r >= QW'(cnt_r)) begin
            rank_r <= IW'(cnt_r - CW'(1));
          end else begin
            rank_r <= IW'(quot_r);
          end
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (rank_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            rank_r <= rank_r - IW'(1);
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {col_r, cell_val[0]};
            count_r     <= '0;
            state_r     <= ST_FILL;
          end
        end
        default: state_r <= ST_FILL;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (count_r < CW'(MAX_SAMPLES)))
    else $error("chain full while filling");

  a_rank_in_column: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (CW'(rank_r) < cnt_r))
    else $error("selected rank outside the column");

  a_result_empties_chain: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_OUT && state_r == ST_FILL) |-> (count_r == '0 && out_valid_r))
    else $error("result loaded without emptying the chain");

  a_hold_after_column: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && NW'(count_inc) >= n_eff) |=> !in_tready)
    else $error("sample taken while a column closes");
`endif

endmodule
`default_nettype wire
